### rtl/core/lpim_pkg.sv
// Package for the linear probe index map: sizes, status and operation codes,
// slot store entry and RAM request types. No dependencies.
// SLOTS must be a power of two; the home slot is taken from the low key bits.
`default_nettype none
package lpim_pkg;

   localparam int unsigned SLOTS    = 64;
   localparam int unsigned SlotW    = $clog2(SLOTS);
   localparam int unsigned CountW   = $clog2(SLOTS) + 1;
   localparam int unsigned KeyW     = 64;
   localparam int unsigned ValueW   = 32;
   localparam int unsigned LimitW   = 7;
   localparam int unsigned StatusW  = 2;
   localparam int unsigned RspSlotW = 6;

   localparam logic [LimitW-1:0] LimitReset = 7'd11;

   localparam logic [StatusW-1:0] STATUS_OK        = 2'd0;
   localparam logic [StatusW-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [StatusW-1:0] STATUS_FULL      = 2'd2;

   localparam logic OP_SET = 1'b0;
   localparam logic OP_GET = 1'b1;

   typedef logic [SlotW-1:0] slot_type;

   typedef struct packed {
      logic [KeyW-1:0]   key;
      logic [ValueW-1:0] value;
   } entry_type;

   typedef struct packed {
      slot_type  rd_addr;
      logic      wr_en;
      slot_type  wr_addr;
      entry_type wr_data;
   } ram_req_type;

endpackage
`default_nettype wire

### rtl/core/linear_probe_index_map.sv
// Linear probe index map: open-addressing key/value map over a slot RAM.
// Depends on lpim_pkg, lpim_ram and lpim_probe_ctrl.
// Each item examines up to SLOTS slots, one per cycle through the RAM read port;
// the result strobe is registered from the last probe step, and busy drops with it.
// A new item is taken only while busy is low; a set with SLOTS-1 or more live entries ends FULL at once.
// Reset clears used bits and live count at once and loads probe_limit with 11; no sweep.
`default_nettype none
module linear_probe_index_map import lpim_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic                req_operation,
   input  wire logic [KeyW-1:0]     req_key,
   input  wire logic [ValueW-1:0]   req_new_value,
   output logic                     rsp_valid,
   output logic      [StatusW-1:0]  rsp_status,
   output logic      [ValueW-1:0]   rsp_read_value,
   output logic      [RspSlotW-1:0] rsp_slot,
   input  wire logic                csr_wr_en,
   input  wire logic [LimitW-1:0]   csr_wr_data
);

   logic [LimitW-1:0] probe_limit_ff;
   ram_req_type       ram_req;
   entry_type         ram_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_limit_ff <= LimitReset;
      end else if (csr_wr_en) begin
         probe_limit_ff <= csr_wr_data;
      end
   end

   lpim_ram #(
      .Width ($bits(entry_type)),
      .Depth (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   lpim_probe_ctrl u_probe_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_key        (req_key),
      .req_new_value  (req_new_value),
      .probe_limit    (probe_limit_ff),
      .ram_req        (ram_req),
      .ram_rd_data    (ram_rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_slot       (rsp_slot)
   );

endmodule
`default_nettype wire

### rtl/core/lpim_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module lpim_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/core/lpim_probe_ctrl.sv
// Probe sequencer: walks the slot store one slot a cycle, holds the used bits
// and live count, and registers the result. Depends on lpim_pkg.
`default_nettype none
module lpim_probe_ctrl import lpim_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_operation,
   input  wire logic [KeyW-1:0]      req_key,
   input  wire logic [ValueW-1:0]    req_new_value,
   input  wire logic [LimitW-1:0]    probe_limit,
   output ram_req_type               ram_req,
   input  wire entry_type            ram_rd_data,
   output logic                      rsp_valid,
   output logic      [StatusW-1:0]   rsp_status,
   output logic      [ValueW-1:0]    rsp_read_value,
   output logic      [RspSlotW-1:0]  rsp_slot
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_PROBE = 1'b1;

   logic                state_ff, state_in;
   slot_type            pos_ff, pos_in;
   logic [CountW-1:0]   steps_ff, steps_in;
   logic [SLOTS-1:0]    used_ff;
   logic [CountW-1:0]   live_count_ff;
   logic                op_ff;
   logic [KeyW-1:0]     key_ff;
   logic [ValueW-1:0]   value_ff;
   slot_type            home_ff;
   logic                full_ff;

   logic                rsp_valid_ff;
   logic [StatusW-1:0]  rsp_status_ff;
   logic [ValueW-1:0]   rsp_read_value_ff;
   logic [RspSlotW-1:0] rsp_slot_ff;

   logic                used_cur, hit, wrapped, over;
   slot_type            nxt;
   logic [CountW-1:0]   steps_nxt;
   logic                done, wr_en, bump;
   logic [StatusW-1:0]  res_status;
   logic [ValueW-1:0]   res_value;
   slot_type            res_slot;
   slot_type            rd_addr;

   assign used_cur  = used_ff[pos_ff];
   assign hit       = (ram_rd_data.key == key_ff);
   assign nxt       = (pos_ff == slot_type'(SLOTS - 1)) ? '0 : pos_ff + 1'b1;
   assign steps_nxt = steps_ff + 1'b1;
   assign wrapped   = (nxt == home_ff);
   assign over      = (steps_nxt > CountW'(probe_limit));

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      steps_in   = steps_ff;
      done       = 1'b0;
      wr_en      = 1'b0;
      bump       = 1'b0;
      res_status = STATUS_OK;
      res_value  = '0;
      res_slot   = pos_ff;
      rd_addr    = nxt;
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = req_key[SlotW-1:0];
            if (start) begin
               state_in = ST_PROBE;
               pos_in   = req_key[SlotW-1:0];
               steps_in = '0;
            end
         end
         ST_PROBE: begin
            if (op_ff == OP_SET) begin
               if (full_ff) begin
                  done       = 1'b1;
                  res_status = STATUS_FULL;
               end else if (!used_cur || hit) begin
                  done  = 1'b1;
                  wr_en = 1'b1;
                  bump  = !used_cur;
               end else if (wrapped || over) begin
                  done       = 1'b1;
                  res_status = STATUS_FULL;
               end else begin
                  pos_in   = nxt;
                  steps_in = steps_nxt;
               end
            end else begin
               if (!used_cur) begin
                  done       = 1'b1;
                  res_status = STATUS_NOT_FOUND;
               end else if (hit) begin
                  done      = 1'b1;
                  res_value = ram_rd_data.value;
               end else if (wrapped) begin
                  done       = 1'b1;
                  res_status = STATUS_NOT_FOUND;
               end else begin
                  pos_in = nxt;
               end
            end
            if (res_status != STATUS_OK) begin
               res_slot = '0;
            end
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         live_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= done;
         if (wr_en) begin
            used_ff[pos_ff] <= 1'b1;
         end
         if (bump) begin
            live_count_ff <= live_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      steps_ff <= steps_in;
      if (state_ff == ST_IDLE && start) begin
         op_ff    <= req_operation;
         key_ff   <= req_key;
         value_ff <= req_new_value;
         home_ff  <= req_key[SlotW-1:0];
         full_ff  <= (live_count_ff >= CountW'(SLOTS - 1));
      end
      if (done) begin
         rsp_status_ff     <= res_status;
         rsp_read_value_ff <= res_value;
         rsp_slot_ff       <= RspSlotW'(res_slot);
      end
   end

   assign busy            = state_ff;
   assign ram_req.rd_addr = rd_addr;
   assign ram_req.wr_en   = wr_en;
   assign ram_req.wr_addr = pos_ff;
   assign ram_req.wr_data = '{key: key_ff, value: value_ff};

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_slot       = rsp_slot_ff;

endmodule
`default_nettype wire

### rtl/core/lpim_checker.sv
// Port-level checker for linear_probe_index_map, bound to the top level.
// Depends on lpim_pkg.
`default_nettype none
module lpim_checker import lpim_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire logic                busy,
   input wire logic                rsp_valid,
   input wire logic [StatusW-1:0]  rsp_status,
   input wire logic [ValueW-1:0]   rsp_read_value,
   input wire logic [RspSlotW-1:0] rsp_slot
);

   a_transfer_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after transfer");

   a_result_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_slot == '0 && rsp_read_value == '0)
      else $error("failed result carries nonzero slot or value");

endmodule

bind linear_probe_index_map lpim_checker u_lpim_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_read_value (rsp_read_value),
   .rsp_slot       (rsp_slot)
);
`default_nettype wire
